FILE: hw/rtl/cgha_pkg.sv
// shared constants, types and helper functions of the chaos game hit accumulator
`timescale 1ns / 1ps

package cgha_pkg;

	localparam int SIDE        = 1024;
	localparam int MAX_CORNERS = 6;

	localparam int COORD_W     = 10;
	localparam int COUNT_W     = 9;
	localparam int SEL_W       = 3;
	localparam int CFG_W       = 20;
	localparam int REG_IDX_W   = 3;
	localparam int NUM_CORNERS = 6;
	localparam int ACT_W       = 2;

	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 32;

	localparam int DEPTH       = SIDE * SIDE;
	localparam int ADDR_W      = $clog2(DEPTH);

	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int HUE_LIMIT   = 360;
	localparam int MONO_LIMIT  = 256;

	localparam logic [COORD_W-1:0] START_ROW =
		COORD_W'((SIDE / 2 > COORD_MAX) ? COORD_MAX : SIDE / 2);

	localparam logic [ACT_W-1:0] ACT_PLOT    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

	localparam logic [ACT_W-1:0] KIND_PLOTTED   = 2'd0;
	localparam logic [ACT_W-1:0] KIND_READ      = 2'd1;
	localparam logic [ACT_W-1:0] KIND_RESTARTED = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_INCREMENT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HUE_MODE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CORNER_ZERO = 3'd2;

	typedef struct packed {
		logic                valid;
		logic [ACT_W-1:0]    kind;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [ADDR_W-1:0]   addr;
		logic                in_pic;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  inc;
		logic                hue;
	} mode_t;

	function automatic logic [SEL_W-1:0] corner_sel(input logic [SEL_W-1:0] sel);
		return (sel >= SEL_W'(MAX_CORNERS)) ? sel - SEL_W'(MAX_CORNERS) : sel;
	endfunction

	function automatic logic in_picture(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		return (32'(col) < 32'(SIDE)) && (32'(row) < 32'(SIDE));
	endfunction

	function automatic logic [ADDR_W-1:0] pixel_index(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		return ADDR_W'(32'(row) * 32'(SIDE) + 32'(col));
	endfunction

endpackage

FILE: hw/rtl/chaos_game_hit_accumulator_unit.sv
// top level of the chaos game hit accumulator
`timescale 1ns / 1ps

// Plots a chaos-game walk into a SIDE x SIDE memory of 9-bit hit counts. After reset the
// count memory is cleared one entry per cycle; s_tready stays low during that pass while
// configuration writes are still taken. After that one item (plot step, pixel read or
// restart) is accepted every cycle unless the output holds it back. An item's ram read is
// taken at the accepting edge and the item is registered in the request stage; its count
// is updated and its result loaded into the output register at the edge where it leaves
// that stage, which a held output delays. A result held by a low m_tready holds s_tready
// low only while the item behind it is also waiting. Unless held, the read-modify-write of
// the single count memory sustains one item per cycle by forwarding the count written by
// the item just ahead. An item with action 3 is accepted and gives no result.

module chaos_game_hit_accumulator_unit import cgha_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // corner_index, read_column, read_row
	input  logic [ACT_W-1:0]      s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_column, pixel_row, hit_count
	output logic [ACT_W-1:0]      m_tuser    // result_kind
);

	req_t               req_s1;
	mode_t              mode;
	logic               advance;
	logic               clearing;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [COUNT_W-1:0] rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [COUNT_W-1:0] wr_data;

	cgha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.advance   (advance),
		.clearing  (clearing),
		.req_s1    (req_s1),
		.mode      (mode),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	cgha_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cgha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_s1   (req_s1),
		.mode     (mode),
		.rd_data  (rd_data),
		.advance  (advance),
		.clearing (clearing),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hw/rtl/cgha_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cgha_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/cgha_front.sv
// config registers, point walk, request stage and ram read issue
`timescale 1ns / 1ps

module cgha_front import cgha_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [ACT_W-1:0]      s_tuser,
	input  logic                  advance,
	input  logic                  clearing,
	output req_t                  req_s1,
	output mode_t                 mode,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr
);

	logic [COUNT_W-1:0] inc_q;
	logic               hue_q;
	logic [CFG_W-1:0]   corners_q [NUM_CORNERS];
	logic [COORD_W-1:0] point_col_q;
	logic [COORD_W-1:0] point_row_q;

	logic               valid_s1;
	req_t               pay_s1;
	req_t               req_next;

	logic               accept;
	logic [CFG_W-1:0]   corner;
	logic [COORD_W-1:0] step_col;
	logic [COORD_W-1:0] step_row;

	assign s_tready = !clearing && advance;
	assign accept   = s_tvalid && s_tready;

	assign corner   = corners_q[corner_sel(s_tdata[2:0])];
	assign step_col = COORD_W'((11'(point_col_q) + 11'(corner[9:0])) >> 1);
	assign step_row = COORD_W'((11'(point_row_q) + 11'(corner[19:10])) >> 1);

	always_comb begin
		req_next        = '0;
		req_next.valid  = accept && (s_tuser != ACT_NONE);
		req_next.kind   = s_tuser;
		case (s_tuser)
			ACT_PLOT: begin
				req_next.col = step_col;
				req_next.row = step_row;
			end
			ACT_READ: begin
				req_next.col = s_tdata[12:3];
				req_next.row = s_tdata[22:13];
			end
			default: begin
				req_next.col = corners_q[0][9:0];
				req_next.row = START_ROW;
			end
		endcase
		req_next.in_pic = in_picture(req_next.col, req_next.row);
		req_next.addr   = pixel_index(req_next.col, req_next.row);
	end

	assign rd_en   = accept && ((s_tuser == ACT_PLOT) || (s_tuser == ACT_READ));
	assign rd_addr = req_next.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= COUNT_W'(1);
			hue_q <= 1'b1;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				corners_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INCREMENT: inc_q <= cfg_data[COUNT_W-1:0];
				REG_HUE_MODE:  hue_q <= cfg_data[0];
				default:       corners_q[3'(cfg_index - REG_CORNER_ZERO)] <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_col_q <= '0;
			point_row_q <= START_ROW;
		end else if (accept && ((s_tuser == ACT_PLOT) || (s_tuser == ACT_RESTART))) begin
			point_col_q <= req_next.col;
			point_row_q <= req_next.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pay_s1 <= req_next;
		end
	end

	always_comb begin
		req_s1       = pay_s1;
		req_s1.valid = valid_s1;
	end

	assign mode.inc = inc_q;
	assign mode.hue = hue_q;

endmodule

FILE: hw/rtl/cgha_back.sv
// count update with forwarding, ram write, clearing pass and output register
`timescale 1ns / 1ps

module cgha_back import cgha_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req_s1,
	input  mode_t                 mode,
	input  logic [COUNT_W-1:0]    rd_data,
	output logic                  advance,
	output logic                  clearing,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [COUNT_W-1:0]    wr_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [ACT_W-1:0]      m_tuser
);

	logic               clr_busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	logic               last_valid_q;
	logic [ADDR_W-1:0]  last_addr_q;
	logic [COUNT_W-1:0] last_data_q;

	logic               out_valid_q;
	logic [ACT_W-1:0]   out_kind_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               fire;
	logic               plot_wr;
	logic [COUNT_W-1:0] old_count;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] new_count;
	logic [COUNT_W-1:0] res_count;

	assign clearing = clr_busy_q;
	assign fire     = req_s1.valid && (!out_valid_q || m_tready);
	assign advance  = !req_s1.valid || fire;

	// the write of the item just ahead lands at the edge this item's read was taken
	assign old_count = (last_valid_q && (last_addr_q == req_s1.addr)) ? last_data_q : rd_data;
	assign sum       = (COUNT_W + 1)'(old_count) + (COUNT_W + 1)'(mode.inc);

	always_comb begin
		if (mode.hue) begin
			new_count = (sum < (COUNT_W + 1)'(HUE_LIMIT)) ? COUNT_W'(sum) : COUNT_W'(HUE_LIMIT);
		end else begin
			new_count = (sum < (COUNT_W + 1)'(MONO_LIMIT)) ? COUNT_W'(sum) : old_count;
		end
		case (req_s1.kind)
			KIND_PLOTTED: res_count = req_s1.in_pic ? new_count : '0;
			KIND_READ:    res_count = req_s1.in_pic ? old_count : '0;
			default:      res_count = '0;
		endcase
	end

	assign plot_wr = fire && (req_s1.kind == KIND_PLOTTED) && req_s1.in_pic;

	assign wr_en   = clr_busy_q || plot_wr;
	assign wr_addr = clr_busy_q ? clr_addr_q : req_s1.addr;
	assign wr_data = clr_busy_q ? '0 : new_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
		end else if (plot_wr) begin
			last_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (plot_wr) begin
			last_addr_q <= req_s1.addr;
			last_data_q <= new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_kind_q  <= req_s1.kind;
			out_col_q   <= req_s1.col;
			out_row_q   <= req_s1.row;
			out_count_q <= res_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {(OUT_DATA_W - COUNT_W - 2 * COORD_W)'(0), out_count_q, out_row_q,
		out_col_q};

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !req_s1.valid)
		else $error("request stage busy during clearing pass");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !clr_busy_q) |-> (wr_data <= COUNT_W'(HUE_LIMIT)))
		else $error("stored count above hue limit");

	a_fire_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("finished item not presented");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_RESTARTED)) |-> (out_count_q == '0))
		else $error("restart result with nonzero count");

endmodule
